FILE: src/assert_macros.svh
// Assertion helpers used by the keypad checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the reset input is low.
`define KMD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("keypad checker: same-cycle property failed");

// Next-cycle implication, disabled while the reset input is low.
`define KMD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("keypad checker: next-cycle property failed");

`endif

FILE: src/kmd_pkg.sv
`default_nettype none

package kmd_pkg;

    // Width of the scan word and of the per-key debounce counter.
    localparam int INPUT_BITS = 16;
    localparam int CNT_W      = 4;
    localparam int FIELD_W    = 2;

    localparam logic [CNT_W-1:0] COUNT_RESET = 4'd3;

    // One memory entry per key.
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             mark;
    } entry_t;

endpackage

`default_nettype wire

FILE: src/keypad_matrix_debounce_top.sv
// Debounced scanner for a NUM_ROWS x NUM_COLS key matrix.
// Input channel (s_valid / s_ready): one item is one full scan, s_pressed_bits,
// bit col*NUM_ROWS+row set when that key reads pressed.
// Result channel (m_valid / m_ready): exactly one item per scan, carrying
// m_key_valid and the row and column of the newly debounced key, or zeros.
// cfg_we / cfg_wdata write the press threshold (reset value 3); write it only
// while no scan is in flight.
// Per-key counters and reported marks live in a one-port-read, one-port-write
// memory. Each key's entry is read in the cycle before that key is processed
// and is written back while the next key is fetched. The walk stops at the
// first key that is reported.
// A new scan is accepted only once the previous scan's result has been loaded
// into the output register.
// Reset clears all counters and marks at once through per-entry valid bits,
// so the block is ready in the first cycle after reset.
// A stalled receiver holds the result in the output register; the next scan
// can be accepted and walked meanwhile, and its result waits until the
// output register frees up.
`default_nettype none

module keypad_matrix_debounce_top
    import kmd_pkg::*;
#(
    parameter int NUM_ROWS = 4,
    parameter int NUM_COLS = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CNT_W-1:0]      cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [INPUT_BITS-1:0] s_pressed_bits,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_key_valid,
    output logic [FIELD_W-1:0]         m_key_row,
    output logic [FIELD_W-1:0]         m_key_col
);

    localparam int NUM_KEYS = NUM_ROWS * NUM_COLS;
    localparam int KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int COL_W    = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;

    logic [CNT_W-1:0] press_thresh_reg;
    logic             rd_en;
    logic [KEY_W-1:0] rd_addr;
    entry_t           rd_data;
    logic             wr_en;
    logic [KEY_W-1:0] wr_addr;
    entry_t           wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_thresh_reg <= COUNT_RESET;
        end else if (cfg_we) begin
            press_thresh_reg <= cfg_wdata;
        end
    end

    kmd_key_mem #(
        .DEPTH  (NUM_KEYS),
        .ADDR_W (KEY_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    kmd_scan_ctrl #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS),
        .NUM_KEYS (NUM_KEYS),
        .KEY_W    (KEY_W),
        .ROW_W    (ROW_W),
        .COL_W    (COL_W)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .press_thresh   (press_thresh_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pressed_bits (s_pressed_bits),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_key_valid    (m_key_valid),
        .m_key_row      (m_key_row),
        .m_key_col      (m_key_col),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data)
    );

endmodule

`default_nettype wire

FILE: src/kmd_key_mem.sv
`default_nettype none

module kmd_key_mem
    import kmd_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output entry_t                 rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire entry_t            wr_data
);

    entry_t           mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    entry_t           rd_data_reg;
    logic             rd_valid_reg;

    // Entries never written since reset read as zero through their valid bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

FILE: src/kmd_scan_ctrl.sv
`default_nettype none

module kmd_scan_ctrl
    import kmd_pkg::*;
#(
    parameter int NUM_ROWS = 4,
    parameter int NUM_COLS = 4,
    parameter int NUM_KEYS = 16,
    parameter int KEY_W    = 4,
    parameter int ROW_W    = 2,
    parameter int COL_W    = 2
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [CNT_W-1:0]      press_thresh,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [INPUT_BITS-1:0] s_pressed_bits,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_key_valid,
    output logic [FIELD_W-1:0]         m_key_row,
    output logic [FIELD_W-1:0]         m_key_col,
    output logic                       rd_en,
    output logic [KEY_W-1:0]           rd_addr,
    input  wire entry_t                rd_data,
    output logic                       wr_en,
    output logic [KEY_W-1:0]           wr_addr,
    output entry_t                     wr_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [INPUT_BITS-1:0]   bits_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [COL_W-1:0]        col_reg;
    logic                    hit_reg;
    logic [FIELD_W-1:0]      res_row_reg;
    logic [FIELD_W-1:0]      res_col_reg;
    logic                    m_valid_reg;
    logic                    m_key_valid_reg;
    logic [FIELD_W-1:0]      m_key_row_reg;
    logic [FIELD_W-1:0]      m_key_col_reg;

    logic [NUM_KEYS-1:0]     down_vec;
    logic                    down;
    logic [CNT_W-1:0]        cnt_next;
    logic                    hit;
    logic                    last_key;
    logic                    accept;
    logic                    load_out;

    // Keys beyond the scan word always read released.
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_down
        if (k < INPUT_BITS) begin : g_in
            assign down_vec[k] = bits_reg[k];
        end else begin : g_out
            assign down_vec[k] = 1'b0;
        end
    end

    assign down     = down_vec[key_reg];
    assign last_key = (key_reg == KEY_W'(NUM_KEYS - 1));
    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Read-modify-write of the entry that came back from memory this cycle.
    always_comb begin
        cnt_next = rd_data.cnt;
        if (rd_data.cnt < press_thresh) begin
            cnt_next = CNT_W'(rd_data.cnt + 1'b1);
        end
        hit = down && (cnt_next == press_thresh) && !rd_data.mark;
        wr_en   = (state_reg == ST_SCAN);
        wr_addr = key_reg;
        if (down) begin
            wr_data.cnt  = cnt_next;
            wr_data.mark = rd_data.mark || hit;
        end else begin
            wr_data = '0;
        end
    end

    // The next key is fetched while the current one is written back.
    always_comb begin
        rd_en   = accept || ((state_reg == ST_SCAN) && !hit && !last_key);
        rd_addr = (state_reg == ST_IDLE) ? '0 : KEY_W'(key_reg + 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            key_reg         <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            hit_reg         <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        bits_reg  <= s_pressed_bits;
                        key_reg   <= '0;
                        row_reg   <= '0;
                        col_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (hit || last_key) begin
                        hit_reg     <= hit;
                        res_row_reg <= hit ? FIELD_W'(row_reg) : '0;
                        res_col_reg <= hit ? FIELD_W'(col_reg) : '0;
                        state_reg   <= ST_DONE;
                    end else begin
                        key_reg <= KEY_W'(key_reg + 1'b1);
                        if (row_reg == ROW_W'(NUM_ROWS - 1)) begin
                            row_reg <= '0;
                            col_reg <= COL_W'(col_reg + 1'b1);
                        end else begin
                            row_reg <= ROW_W'(row_reg + 1'b1);
                        end
                    end
                end
                ST_DONE: begin
                    if (load_out) begin
                        m_key_valid_reg <= hit_reg;
                        m_key_row_reg   <= res_row_reg;
                        m_key_col_reg   <= res_col_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_key_valid = m_key_valid_reg;
    assign m_key_row   = m_key_row_reg;
    assign m_key_col   = m_key_col_reg;

endmodule

`default_nettype wire

FILE: src/kmd_checker.sv
`default_nettype none
`include "assert_macros.svh"

module kmd_checker
    import kmd_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic                  m_key_valid,
    input wire logic [FIELD_W-1:0]    m_key_row,
    input wire logic [FIELD_W-1:0]    m_key_col
);

    logic [2*FIELD_W-1:0] m_coords;
    logic [2*FIELD_W:0]   m_fields;

    assign m_coords = {m_key_row, m_key_col};
    assign m_fields = {m_key_valid, m_coords};

    // A stalled result stays offered and unchanged.
    `KMD_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `KMD_ASSERT_NXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_fields))

    // A result without a key carries zero coordinates.
    `KMD_ASSERT_NOW(a_idle_zero, aclk, aresetn, m_valid && !m_key_valid, m_coords == '0)

    // The scan of an accepted item blocks the input in the cycle after acceptance.
    `KMD_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // No result is offered right after reset.
    `KMD_ASSERT_NXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_valid)

endmodule

bind keypad_matrix_debounce_top kmd_checker u_kmd_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_keypad_matrix_debounce_top.sv
`timescale 1ns / 1ps

module tb_keypad_matrix_debounce_top;
    import kmd_pkg::*;

    localparam int NUM_KEYS    = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic               key_valid;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
    } key_report_t;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  cfg_we         = 1'b0;
    logic [CNT_W-1:0]      cfg_wdata      = '0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [INPUT_BITS-1:0] s_pressed_bits = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic                  m_key_valid;
    logic [FIELD_W-1:0]    m_key_row;
    logic [FIELD_W-1:0]    m_key_col;

    // Predicted state of the debouncer.
    logic [CNT_W-1:0] debounce_setting = COUNT_RESET;
    logic [CNT_W-1:0] key_counts [NUM_KEYS];
    bit               key_reported [NUM_KEYS];

    key_report_t expected_reports[$];

    int unsigned tx_gap_odds   = 0;
    int unsigned rx_stall_odds = 0;
    int unsigned cycle_count   = 0;
    int unsigned mismatch_count = 0;
    int unsigned scans_sent    = 0;
    int unsigned keys_reported = 0;
    logic [15:0] counts_written = '0;

    keypad_matrix_debounce_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pressed_bits (s_pressed_bits),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_key_valid    (m_key_valid),
        .m_key_row      (m_key_row),
        .m_key_col      (m_key_col)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_reports.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Walks the keys column by column and stops at the first new report.
    function automatic key_report_t predict_key_report(input logic [INPUT_BITS-1:0] bits);
        key_report_t rep;
        int          pos;
        rep = '0;
        for (pos = 0; pos < NUM_KEYS; pos++) begin
            if (bits[pos]) begin
                if (key_counts[pos] < debounce_setting)
                    key_counts[pos] = key_counts[pos] + 1'b1;
                if (key_counts[pos] == debounce_setting && !key_reported[pos]) begin
                    key_reported[pos] = 1'b1;
                    rep.key_valid     = 1'b1;
                    rep.row           = FIELD_W'(pos % 4);
                    rep.col           = FIELD_W'(pos / 4);
                    return rep;
                end
            end else begin
                key_counts[pos]   = '0;
                key_reported[pos] = 1'b0;
            end
        end
        return rep;
    endfunction

    always @(posedge aclk) begin
        key_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (m_key_valid === 1'b1)
                keys_reported++;
            if (expected_reports.size() == 0) begin
                report_mismatch("result item arrived with nothing expected");
            end else begin
                want = expected_reports.pop_front();
                if (m_key_valid !== want.key_valid)
                    report_mismatch($sformatf("key_valid got %b expected %b",
                                              m_key_valid, want.key_valid));
                if (m_key_row !== want.row)
                    report_mismatch($sformatf("key_row got %0d expected %0d",
                                              m_key_row, want.row));
                if (m_key_col !== want.col)
                    report_mismatch($sformatf("key_col got %0d expected %0d",
                                              m_key_col, want.col));
            end
        end
    end

    // Receiver: ready drops for random bursts while stalls are enabled.
    initial begin
        int unsigned stall;
        forever begin
            @(posedge aclk);
            if (rx_stall_odds != 0 && $urandom_range(1, 100) <= rx_stall_odds) begin
                stall = $urandom_range(1, 15);
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic send_scan(input logic [INPUT_BITS-1:0] bits);
        int unsigned gap;
        if (tx_gap_odds != 0 && $urandom_range(1, 100) <= tx_gap_odds) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_pressed_bits <= bits;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected_reports.push_back(predict_key_report(bits));
        scans_sent++;
    endtask

    // Always waits on the clock before returning, so valid is never lowered and raised
    // in the same step.
    task automatic wait_all_reported();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (expected_reports.size() != 0);
    endtask

    // Only called with the block idle.
    task automatic set_debounce(input logic [CNT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        debounce_setting      = value;
        counts_written[value] = 1'b1;
    endtask

    task automatic send_repeated(input logic [INPUT_BITS-1:0] bits, input int unsigned n);
        repeat (n) send_scan(bits);
    endtask

    // Reset count of three: a key reports on its third pressed scan, once.
    task automatic test_default_count();
        tx_gap_odds   = 25;
        rx_stall_odds = 25;
        send_repeated(16'h0001, 4);
        send_scan(16'h0000);
    endtask

    // A count of zero reports a key on its first pressed scan.
    task automatic test_zero_count();
        wait_all_reported();
        set_debounce(4'd0);
        send_repeated(16'h8000, 2);
        send_scan(16'h0000);
    endtask

    // With every key down, one key is reported per scan in column-major order.
    task automatic test_scan_order();
        wait_all_reported();
        set_debounce(4'd1);
        send_repeated(16'hFFFF, 4);
        send_scan(16'h0000);
    endtask

    // A counter above a lowered count stays stuck until the key is released.
    task automatic test_lowered_count();
        wait_all_reported();
        set_debounce(4'd5);
        send_repeated(16'h0100, 3);
        wait_all_reported();
        set_debounce(4'd2);
        send_repeated(16'h0100, 2);
        send_scan(16'h0000);
        send_repeated(16'h0100, 2);
    endtask

    // Results back up behind a slow receiver, then the sender holds off
    // until every one of them has come out.
    task automatic test_pause_for_drain();
        int unsigned k;
        wait_all_reported();
        set_debounce(4'd1);
        tx_gap_odds   = 0;
        rx_stall_odds = 70;
        for (k = 0; k < 8; k++)
            send_scan(INPUT_BITS'($urandom()));
        wait_all_reported();
        for (k = 0; k < 8; k++)
            send_scan(INPUT_BITS'($urandom()));
    endtask

    function automatic logic [INPUT_BITS-1:0] pick_hold_pattern();
        case ($urandom_range(0, 9))
            0:       return 16'hFFFF;
            1:       return 16'h0000;
            2, 3:    return 16'h0001 << $urandom_range(0, 15);
            4:       return INPUT_BITS'($urandom());
            default: return INPUT_BITS'($urandom() & $urandom() & $urandom());
        endcase
    endfunction

    // Mostly keys held steady for a random span, often long enough to debounce, with occasional
    // bounce on one bit; the rest is unrelated random scans.
    task automatic run_random_phase(input int unsigned n_items);
        logic [INPUT_BITS-1:0] hold;
        logic [INPUT_BITS-1:0] scan;
        int unsigned           span;
        int unsigned           i;
        int unsigned           k;
        i = 0;
        while (i < n_items) begin
            if ($urandom_range(0, 99) < 15) begin
                send_scan(INPUT_BITS'($urandom()));
                i++;
            end else begin
                hold = pick_hold_pattern();
                span = $urandom_range(1, debounce_setting + 6);
                if (hold == 16'hFFFF)
                    span = span + $urandom_range(0, 16);
                for (k = 0; k < span && i < n_items; k++) begin
                    scan = hold;
                    if ($urandom_range(0, 99) < 8)
                        scan = scan ^ (16'h0001 << $urandom_range(0, 15));
                    send_scan(scan);
                    i++;
                end
            end
        end
    endtask

    task automatic test_random_traffic();
        int unsigned           odds_menu [4] = '{0, 10, 30, 60};
        logic [CNT_W-1:0]      phase_counts [10] =
            '{4'd1, 4'd0, 4'd15, 4'd2, 4'd3, 4'd7, 4'd5, 4'd4, 4'd9, 4'd3};
        int unsigned           p;
        for (p = 0; p < 10; p++) begin
            wait_all_reported();
            if (p >= 8)
                set_debounce(CNT_W'($urandom_range(0, 15)));
            else
                set_debounce(phase_counts[p]);
            if (p == 9) begin
                // Closing stretch runs at full rate on both sides.
                tx_gap_odds   = 0;
                rx_stall_odds = 0;
            end else begin
                tx_gap_odds   = odds_menu[$urandom_range(0, 3)];
                rx_stall_odds = odds_menu[$urandom_range(0, 3)];
            end
            run_random_phase(135);
        end
    endtask

    initial begin
        int k;
        for (k = 0; k < NUM_KEYS; k++) begin
            key_counts[k]   = '0;
            key_reported[k] = 1'b0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_default_count();
        test_zero_count();
        test_scan_order();
        test_lowered_count();
        test_pause_for_drain();
        test_random_traffic();

        wait_all_reported();
        repeat (24) @(posedge aclk);

        $display("Sent %0d scans; %0d key presses were reported.", scans_sent, keys_reported);
        $display("Debounce counts exercised (bit per value): %b; %0d mismatches.",
                 counts_written, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/kmd_pkg.sv
src/kmd_key_mem.sv
src/kmd_scan_ctrl.sv
src/keypad_matrix_debounce_top.sv
src/kmd_checker.sv
tb/sv/tb_keypad_matrix_debounce_top.sv
